### hw/rtl/wfre_pkg.sv
// ----------------------------------------------------------------------------
// wfre_pkg
// Shared types and constants for the windowed frame rate estimator.
// ----------------------------------------------------------------------------
package wfre_pkg;

  localparam int DEPTH   = 64;
  localparam int TS_W    = 62;
  localparam int WIN_W   = 16;
  localparam int FR_W    = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int TH_W    = 36;
  localparam int DIV_NW  = 36;
  localparam int DIV_DW  = 20;
  localparam int DIV_QW  = 18;
  localparam int DREG_W  = DIV_DW + DIV_QW - 1;
  localparam int STEP_W  = $clog2(DIV_QW);

  // One million is 2^6 * 15625; the quotient by 15625 uses a reciprocal
  // that is exact for every 30-bit operand.
  localparam int MS_POW2   = 6;
  localparam int MS_XW     = DIV_NW - MS_POW2;
  localparam int MS_MW     = 31;
  localparam int MS_PW     = MS_XW + MS_MW;
  localparam int MS_RSHIFT = 44;

  localparam logic [IDX_W-1:0]  SCAN_LAST   = IDX_W'(DEPTH - 3);
  localparam logic [IDX_W-1:0]  ROT_LAST    = IDX_W'(DEPTH - 1);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(DIV_QW - 1);
  localparam logic [DIV_DW-1:0] NS_PER_MS   = DIV_DW'(1000000);
  localparam logic [MS_MW-1:0]  MS_RECIP    = MS_MW'(1125899907);
  localparam logic [TS_W-1:0]   EMPTY_BELOW = TS_W'(1000);
  localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(2000);
  localparam logic [DIV_NW-1:0] RATE_SCALE2 = DIV_NW'(2000);
  localparam logic [FR_W-1:0]   RATE_MAX    = '1;
  localparam logic [TH_W-1:0]   THRESH_RESET =
      TH_W'((64'(WIN_RESET) + 64'd1) * 64'(NS_PER_MS));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV_E,
    ST_DIV_R,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic load0;
  } chain_ctl_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/wfre_cell.sv
// ----------------------------------------------------------------------------
// wfre_cell
// One slot of the arrival history; takes its left or right neighbor's value.
// ----------------------------------------------------------------------------
module wfre_cell
  import wfre_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            take_prev,
  input  logic            take_next,
  input  logic [TS_W-1:0] prev_val,
  input  logic [TS_W-1:0] next_val,
  output logic [TS_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (take_prev) begin
      value <= prev_val;
    end else if (take_next) begin
      value <= next_val;
    end
  end

endmodule

### hw/rtl/wfre_div.sv
// ----------------------------------------------------------------------------
// wfre_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfre_div
  import wfre_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIV_NW-1:0] rem;
  logic [DREG_W-1:0] dreg;
  logic [DIV_QW-1:0] quo;
  logic              ge;

  assign ge  = DREG_W'(rem) >= dreg;
  assign rsp = '{done: done, quotient: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dreg <= {req.divisor, {(DIV_QW-1){1'b0}}};
      quo  <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dreg[DIV_NW-1:0];
      end
      quo  <= {quo[DIV_QW-2:0], ge};
      dreg <= dreg >> 1;
    end
  end

endmodule

### hw/rtl/wfre_ctrl.sv
// ----------------------------------------------------------------------------
// wfre_ctrl
// Request handshake, history sequencing, window scan and rate computation.
// ----------------------------------------------------------------------------
module wfre_ctrl
  import wfre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [TS_W-1:0]  timestamp_ns,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] window_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [FR_W-1:0]  frame_rate,
  input  logic [TS_W-1:0]  head,
  input  logic [TS_W-1:0]  tap,
  output chain_ctl_t       ctl,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp
);

  state_t            state;
  state_t            state_next;
  logic [TH_W-1:0]   thresh;
  logic [TS_W-1:0]   now;
  logic [IDX_W-1:0]  rot;
  logic              rot_active;
  logic [IDX_W-1:0]  count;
  logic              last_pos;
  logic [MS_XW-1:0]  last_delta;
  logic [MS_PW-1:0]  ms_prod;
  logic [DIV_QW-1:0] elapsed;
  logic [FR_W-1:0]   result;
  logic [FR_W-1:0]   result_next;
  logic              result_load;
  logic              in_acc;
  logic [TS_W:0]     delta;
  logic              over;
  logic              stop;
  logic              emit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || rot_active;
  assign in_acc    = in_valid && !in_stall;

  assign delta = {1'b0, now} - {1'b0, tap};
  assign over  = !delta[TS_W] && (delta[TS_W-1:0] >= TS_W'(thresh));
  assign stop  = (tap == '0) || over;

  assign ms_prod = MS_PW'(last_delta) * MS_PW'(MS_RECIP);

  assign ctl.shift  = in_acc && !func && (head >= EMPTY_BELOW);
  assign ctl.load0  = in_acc && !func;
  assign ctl.rotate = rot_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_NW'(count) * RATE_SCALE2 + DIV_NW'(elapsed);
    div_req.divisor  = DIV_DW'({elapsed, 1'b0});
    result_next      = FR_W'(count);
    result_load      = 1'b0;
    emit             = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && func) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stop || rot == SCAN_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (count == '0 || !last_pos) begin
          result_load = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          state_next = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        if (elapsed == '0) begin
          result_load = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (div_rsp.done) begin
          result_load = 1'b1;
          result_next = (div_rsp.quotient > DIV_QW'(RATE_MAX)) ? RATE_MAX
                                                               : div_rsp.quotient[FR_W-1:0];
          state_next  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rot_active && (!out_valid || !out_stall)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh     <= THRESH_RESET;
      rot_active <= 1'b0;
      rot        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thresh <= TH_W'((WIN_W+1)'(window_ms) + (WIN_W+1)'(1)) * TH_W'(NS_PER_MS);
      end
      if (in_acc && func) begin
        rot_active <= 1'b1;
        rot        <= '0;
      end else if (rot_active) begin
        rot <= rot + IDX_W'(1);
        if (rot == ROT_LAST) begin
          rot_active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && func) begin
      now   <= timestamp_ns;
      count <= '0;
    end
    if (state == ST_SCAN && !stop) begin
      count      <= count + IDX_W'(1);
      last_pos   <= !delta[TS_W] && (delta != '0);
      last_delta <= delta[DIV_NW-1:MS_POW2];
    end
    if (state == ST_DECIDE) begin
      elapsed <= DIV_QW'(ms_prod[MS_PW-1:MS_RSHIFT]);
    end
    if (result_load) begin
      result <= result_next;
    end
    if (emit) begin
      frame_rate <= result;
    end
  end

endmodule

### hw/rtl/windowed_frame_rate_estimator.sv
// ----------------------------------------------------------------------------
// windowed_frame_rate_estimator
// Frame rate over a sliding window of recorded frame arrival times.
// ----------------------------------------------------------------------------
// An input request carries func and timestamp_ns. A frame event (func 0)
// records its time and gives no result; the next request can follow in
// the next cycle. A rate query (func 1) rotates the 64-slot history once
// around its ring of cells, one place per cycle, and scans it as it passes
// the second cell, so the history is busy while the ring turns. After the
// scan stops, the elapsed milliseconds come from a reciprocal multiply, and,
// unless the scan found no frames or no elapsed time, a one-bit-per-cycle
// divider runs one 18-step division for the rate. A query's length is set
// by the ring rotation and the serial divider; in_stall stays high until done.
// The result goes to an output register; while the receiver stalls it holds,
// and frame events are still accepted. A further query completes only once
// the register is free. window_ms is written through cfg_valid/cfg_ready,
// which is always ready. Reset empties the history, sets the window to
// 2000 ms and clears out_valid.
// ----------------------------------------------------------------------------
module windowed_frame_rate_estimator
  import wfre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [TS_W-1:0]  timestamp_ns,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] window_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [FR_W-1:0]  frame_rate
);

  logic [TS_W-1:0] slot [DEPTH];
  chain_ctl_t      ctl;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      wfre_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .take_prev (ctl.shift || ctl.load0),
        .take_next (ctl.rotate),
        .prev_val  (timestamp_ns),
        .next_val  (slot[(i + 1) % DEPTH]),
        .value     (slot[i])
      );
    end else begin : g_body
      wfre_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .take_prev (ctl.shift),
        .take_next (ctl.rotate),
        .prev_val  (slot[i - 1]),
        .next_val  (slot[(i + 1) % DEPTH]),
        .value     (slot[i])
      );
    end
  end

  wfre_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wfre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .timestamp_ns (timestamp_ns),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_ms    (window_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_rate   (frame_rate),
    .head         (slot[0]),
    .tap          (slot[1]),
    .ctl          (ctl),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

endmodule

### hw/rtl/wfre_chk.sv
// ----------------------------------------------------------------------------
// wfre_chk
// Port-level checks for the windowed frame rate estimator.
// ----------------------------------------------------------------------------
module wfre_chk
  import wfre_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             func,
  input logic             out_valid,
  input logic             out_stall,
  input logic [FR_W-1:0]  frame_rate
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not cleared after reset");

  a_frame_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !func) |=> !in_stall)
    else $error("frame event held the input");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func) |=> in_stall)
    else $error("query did not hold the input");

  a_query_ring: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func) |-> ##63 in_stall)
    else $error("query finished before the history rotation");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(frame_rate))
    else $error("stalled result changed");

endmodule

bind windowed_frame_rate_estimator wfre_chk u_wfre_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .func         (func),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_rate   (frame_rate)
);
